@@ hw/rtl/octal_escape_codec_core_macros.svh @@
// Assertion helpers shared by the codec RTL.
// Both macros sample on the rising edge of i_clk and stay quiet while i_rst_n is low.
`ifndef OCTAL_ESCAPE_CODEC_CORE_MACROS_SVH
`define OCTAL_ESCAPE_CODEC_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OEC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OEC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/oec_pkg.sv @@
package oec_pkg;

    // Characters of the escape syntax and the name terminators.
    localparam logic [7:0] CHAR_BSL   = 8'h5C;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_NL    = 8'h0A;
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;

    // Most bytes one input item can produce, and the width of a byte count.
    localparam int OUT_MAX = 9;
    localparam int CNT_W   = 4;

    // Configuration port geometry and register indexes.
    localparam int         ADDR_W          = 3;
    localparam int         DATA_W          = 32;
    localparam logic [0:0] REG_DECODE_MODE = 1'b0;
    localparam logic [0:0] REG_NUL_TERM    = 1'b1;

    // Lookahead states: how much of a backslash-hash-digits sequence is held.
    localparam logic [2:0] PC_IDLE = 3'd0;
    localparam logic [2:0] PC_BSL  = 3'd1;
    localparam logic [2:0] PC_HASH = 3'd2;
    localparam logic [2:0] PC_DIG1 = 3'd3;
    localparam logic [2:0] PC_DIG2 = 3'd4;

    typedef struct packed {
        logic decode_mode;
        logic nul_terminator;
    } t_cfg;

    typedef struct packed {
        logic [2:0] cnt;
        logic [7:0] d1;
        logic [7:0] d0;
    } t_pend;

    // Element 0 is the first byte sent.
    typedef logic [OUT_MAX-1:0][7:0] t_obuf;

endpackage

@@ hw/rtl/oec_if.sv @@
interface oec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_name;

    modport source (output valid, output data_byte, output end_of_name, input ready);
    modport sink   (input valid, input data_byte, input end_of_name, output ready);
endinterface

interface oec_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

@@ hw/rtl/oec_gen.sv @@
// Works out, for one input item, the bytes it produces and the next lookahead state.
module oec_gen (
    input  logic [7:0]            i_data_byte,
    input  logic                  i_end_of_name,
    input  oec_pkg::t_pend        i_pend,
    input  oec_pkg::t_cfg         i_cfg,
    output oec_pkg::t_obuf        o_list,
    output logic [oec_pkg::CNT_W-1:0] o_count,
    output oec_pkg::t_pend        o_pend
);

    function automatic logic digit_ok(input logic [7:0] c, input logic dec);
        digit_ok = (c >= oec_pkg::CHAR_ZERO) &&
                   (c <= (dec ? oec_pkg::CHAR_SEVEN : oec_pkg::CHAR_NINE));
    endfunction

    // Backslash, hash and three octal digits, first byte in the low bits.
    function automatic logic [39:0] esc_word(input logic [7:0] b);
        esc_word = {oec_pkg::CHAR_ZERO + {5'b0, b[2:0]},
                    oec_pkg::CHAR_ZERO + {5'b0, b[5:3]},
                    oec_pkg::CHAR_ZERO + {6'b0, b[7:6]},
                    oec_pkg::CHAR_HASH, oec_pkg::CHAR_BSL};
    endfunction

    logic [2:0]                  fc;
    oec_pkg::t_obuf              tail;
    logic [oec_pkg::CNT_W-1:0]   tn;
    logic                        use_idle;
    logic [31:0]                 flush_word;
    logic [31:0]                 flush_mask;
    logic [5:0]                  shamt;
    logic [7:0]                  b;
    logic                        dec;

    always_comb begin
        b        = i_data_byte;
        dec      = i_cfg.decode_mode;
        fc       = 3'd0;
        tail     = '0;
        tn       = '0;
        use_idle = 1'b0;
        o_pend   = i_pend;

        if (i_end_of_name) begin
            fc = (i_pend.cnt >= oec_pkg::PC_DIG2) ? oec_pkg::PC_DIG2 : i_pend.cnt;
            tail[0] = (dec && i_cfg.nul_terminator) ? oec_pkg::CHAR_NUL : oec_pkg::CHAR_NL;
            tn = 4'd1;
            o_pend.cnt = oec_pkg::PC_IDLE;
        end else begin
            case (i_pend.cnt)
                oec_pkg::PC_IDLE: begin
                    use_idle = 1'b1;
                end
                oec_pkg::PC_BSL: begin
                    if (b == oec_pkg::CHAR_HASH) begin
                        o_pend.cnt = oec_pkg::PC_HASH;
                    end else begin
                        fc = 3'd1;
                        use_idle = 1'b1;
                    end
                end
                oec_pkg::PC_HASH: begin
                    if (digit_ok(b, dec)) begin
                        o_pend.d0  = b;
                        o_pend.cnt = oec_pkg::PC_DIG1;
                    end else begin
                        fc = 3'd2;
                        use_idle = 1'b1;
                    end
                end
                oec_pkg::PC_DIG1: begin
                    if (digit_ok(b, dec)) begin
                        o_pend.d1  = b;
                        o_pend.cnt = oec_pkg::PC_DIG2;
                    end else begin
                        fc = 3'd3;
                        use_idle = 1'b1;
                    end
                end
                oec_pkg::PC_DIG2: begin
                    if (digit_ok(b, dec) && digit_ok(i_pend.d0, dec) &&
                        digit_ok(i_pend.d1, dec)) begin
                        if (dec) begin
                            tail[0] = {i_pend.d0[1:0], i_pend.d1[2:0], b[2:0]};
                            tn = 4'd1;
                        end else begin
                            // The leading backslash is itself escaped, the rest is literal.
                            tail = {b, i_pend.d1, i_pend.d0, oec_pkg::CHAR_HASH,
                                    esc_word(oec_pkg::CHAR_BSL)};
                            tn = 4'd9;
                        end
                        o_pend.cnt = oec_pkg::PC_IDLE;
                    end else begin
                        fc = 3'd4;
                        use_idle = 1'b1;
                    end
                end
                default: begin
                    use_idle = 1'b1;
                end
            endcase

            if (use_idle) begin
                o_pend.cnt = oec_pkg::PC_IDLE;
                if (b == oec_pkg::CHAR_BSL) begin
                    o_pend.cnt = oec_pkg::PC_BSL;
                end else if (!dec && ((b < oec_pkg::CHAR_SPACE) || (b >= oec_pkg::CHAR_DEL))) begin
                    tail = {32'b0, esc_word(b)};
                    tn = 4'd5;
                end else begin
                    tail[0] = b;
                    tn = 4'd1;
                end
            end
        end
    end

    // Held bytes go first, then the bytes of the new item.
    always_comb begin
        flush_word = {i_pend.d1, i_pend.d0, oec_pkg::CHAR_HASH, oec_pkg::CHAR_BSL};
        case (fc)
            3'd0:    flush_mask = 32'h0000_0000;
            3'd1:    flush_mask = 32'h0000_00FF;
            3'd2:    flush_mask = 32'h0000_FFFF;
            3'd3:    flush_mask = 32'h00FF_FFFF;
            default: flush_mask = 32'hFFFF_FFFF;
        endcase
        shamt   = {fc, 3'b000};
        o_list  = (tail << shamt) | {40'b0, flush_word & flush_mask};
        o_count = {1'b0, fc} + tn;
    end

endmodule

@@ hw/rtl/octal_escape_codec_core.sv @@
// An accepted item waits in the input register, then loads the result register once it is free.
// Throughput: one item per cycle while the receiver is ready and each item yields at most one
// byte; an item that yields n bytes (up to nine) holds the single-byte output register until all leave.
// Reset (synchronous, active low) empties both stages, drops the lookahead and clears
// both configuration registers to zero; no clearing pass is needed.
`include "octal_escape_codec_core_macros.svh"

module octal_escape_codec_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    oec_in_if.sink                         i_in,
    oec_out_if.source                      o_out,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [oec_pkg::ADDR_W-1:0]     paddr,
    input  logic [oec_pkg::DATA_W-1:0]     pwdata,
    output logic [oec_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    // The block is two registers deep. The input register takes one transfer from
    // the upstream side. The generator turns that item plus the held lookahead bytes
    // into a list of up to nine bytes, which loads the result register in one go.
    // The result register then shifts out one byte per output transfer. The input
    // register moves forward when the result register is empty or its final byte is
    // leaving, so a fresh input transfer can land in the same cycle.

    // Configuration registers. A write completes on the access cycle of the APB
    // transfer; the register index is the word address.
    oec_pkg::t_cfg r_cfg;
    logic [0:0]    w_reg_idx;

    assign w_reg_idx = paddr[2];
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_reg_idx)
                oec_pkg::REG_DECODE_MODE: r_cfg.decode_mode    <= pwdata[0];
                oec_pkg::REG_NUL_TERM:    r_cfg.nul_terminator <= pwdata[0];
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            oec_pkg::REG_DECODE_MODE: prdata = {31'b0, r_cfg.decode_mode};
            oec_pkg::REG_NUL_TERM:    prdata = {31'b0, r_cfg.nul_terminator};
            default:                  prdata = '0;
        endcase
    end

    // Input register.
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eon;

    // Result register: remaining byte count and the bytes, next byte at element 0.
    logic [oec_pkg::CNT_W-1:0] r_cnt;
    oec_pkg::t_obuf            r_buf;

    // Lookahead state. Only the count is reset; the digits are written before use.
    oec_pkg::t_pend r_pend;

    oec_pkg::t_obuf            w_gen_list;
    logic [oec_pkg::CNT_W-1:0] w_gen_cnt;
    oec_pkg::t_pend            n_pend;
    logic                      w_adv;
    logic                      w_in_xfer;
    logic                      w_out_xfer;

    oec_gen u_gen (
        .i_data_byte   (r_in_byte),
        .i_end_of_name (r_in_eon),
        .i_pend        (r_pend),
        .i_cfg         (r_cfg),
        .o_list        (w_gen_list),
        .o_count       (w_gen_cnt),
        .o_pend        (n_pend)
    );

    assign o_out.valid       = (r_cnt != '0);
    assign o_out.out_byte    = r_buf[0];
    assign o_out.last_of_run = (r_cnt == 4'd1);

    assign w_out_xfer = o_out.valid && o_out.ready;
    // The held item moves on once the result register is free by the next edge.
    assign w_adv      = r_in_valid && ((r_cnt == '0) || ((r_cnt == 4'd1) && o_out.ready));
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_in_xfer  = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in_byte <= i_in.data_byte;
            r_in_eon  <= i_in.end_of_name;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_pend.cnt <= oec_pkg::PC_IDLE;
        end else if (w_adv) begin
            r_cnt  <= w_gen_cnt;
            r_pend <= n_pend;
        end else if (w_out_xfer) begin
            r_cnt <= r_cnt - 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_buf <= w_gen_list;
        end else if (w_out_xfer) begin
            r_buf <= r_buf >> 8;
        end
    end

    // A stalled output with a full input register must hold off upstream.
    `OEC_ASSERT_SAME(a_no_overrun, (o_out.valid && !o_out.ready && r_in_valid), !i_in.ready, "input taken while both stages are full")
    // The end of a name always leaves nothing held.
    `OEC_ASSERT_NEXT(a_eon_flushes, (w_adv && r_in_eon), (r_pend.cnt == oec_pkg::PC_IDLE), "lookahead survived end of name")
    // A loaded list is presented from its first byte.
    `OEC_ASSERT_NEXT(a_load_shows, (w_adv && (w_gen_cnt != '0)), (o_out.valid && (o_out.out_byte == $past(w_gen_list[0]))), "loaded result not presented")
    // Counts stay within what one item can produce and hold.
    `OEC_ASSERT_SAME(a_cnt_range, 1'b1, ((r_cnt <= 4'd9) && (r_pend.cnt <= oec_pkg::PC_DIG2)), "count out of range")

endmodule

@@ tb/sv/octal_escape_codec_core_test.sv @@
module octal_escape_codec_core_test;
    import oec_pkg::*;

    // One expected output transfer: the byte and whether it closes the run of
    // bytes caused by a single input transfer.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_expected_byte;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    oec_in_if  in_bus ();
    oec_out_if out_bus ();

    octal_escape_codec_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Bytes still owed by the block, oldest first, and the bytes of the run
    // that the predictor is currently building.
    t_expected_byte expected_bytes[$];
    logic [7:0]     run_bytes[$];

    // The predictor's own copy of the configuration and of the lookahead.
    logic       cfg_decode;
    logic       cfg_nul;
    logic [2:0] held_cnt;
    logic [7:0] held_dig0;
    logic [7:0] held_dig1;

    // Percent chance per cycle that the sender idles or the receiver stalls.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;

    int unsigned error_count;
    int unsigned items_sent;
    int unsigned bytes_checked;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: far beyond the slowest correct run, where every item yields
    // nine bytes and each byte sits through a long receiver stall.
    initial begin
        #3000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Predictor. These functions mirror the escape rules: they work on the
    // copy of the lookahead above and append produced bytes to run_bytes.
    // ------------------------------------------------------------------

    // A digit is acceptable if it is octal in decode mode or decimal in
    // encode mode; the mode in force right now decides.
    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= (cfg_decode ? CHAR_SEVEN : CHAR_NINE));
    endfunction

    function automatic void put_escape(input logic [7:0] b);
        run_bytes.push_back(CHAR_BSL);
        run_bytes.push_back(CHAR_HASH);
        run_bytes.push_back(CHAR_ZERO + {6'b0, b[7:6]});
        run_bytes.push_back(CHAR_ZERO + {5'b0, b[5:3]});
        run_bytes.push_back(CHAR_ZERO + {5'b0, b[2:0]});
    endfunction

    // Held lookahead bytes come out literally, in the order they arrived.
    function automatic void flush_held();
        if (held_cnt >= PC_BSL) run_bytes.push_back(CHAR_BSL);
        if (held_cnt >= PC_HASH) run_bytes.push_back(CHAR_HASH);
        if (held_cnt >= PC_DIG1) run_bytes.push_back(held_dig0);
        if (held_cnt >= PC_DIG2) run_bytes.push_back(held_dig1);
        held_cnt = PC_IDLE;
    endfunction

    // A byte seen with nothing held: a backslash may open a sequence, other
    // bytes are escaped in encode mode when they are not printable.
    function automatic void take_fresh(input logic [7:0] b);
        if (b == CHAR_BSL) begin
            held_cnt = PC_BSL;
        end else if (!cfg_decode && (b < CHAR_SPACE || b >= CHAR_DEL)) begin
            put_escape(b);
        end else begin
            run_bytes.push_back(b);
        end
    endfunction

    function automatic void take_byte(input logic [7:0] b);
        case (held_cnt)
            PC_IDLE: begin
                take_fresh(b);
                return;
            end
            PC_BSL: begin
                if (b == CHAR_HASH) begin
                    held_cnt = PC_HASH;
                    return;
                end
            end
            PC_HASH: begin
                if (is_digit(b)) begin
                    held_dig0 = b;
                    held_cnt  = PC_DIG1;
                    return;
                end
            end
            PC_DIG1: begin
                if (is_digit(b)) begin
                    held_dig1 = b;
                    held_cnt  = PC_DIG2;
                    return;
                end
            end
            PC_DIG2: begin
                // Digits held across a mode change are tested again here.
                if (is_digit(b) && is_digit(held_dig0) && is_digit(held_dig1)) begin
                    if (cfg_decode) begin
                        // The value mod 256 keeps only the low two bits of the first digit.
                        run_bytes.push_back({held_dig0[1:0], held_dig1[2:0], b[2:0]});
                    end else begin
                        put_escape(CHAR_BSL);
                        run_bytes.push_back(CHAR_HASH);
                        run_bytes.push_back(held_dig0);
                        run_bytes.push_back(held_dig1);
                        run_bytes.push_back(b);
                    end
                    held_cnt = PC_IDLE;
                    return;
                end
            end
            default: begin
                held_cnt = PC_IDLE;
                take_fresh(b);
                return;
            end
        endcase
        // The sequence broke: release what was held, then treat the new byte
        // as if nothing had been held.
        flush_held();
        take_fresh(b);
    endfunction

    function automatic void predict_transfer(input logic [7:0] b, input logic eon);
        run_bytes.delete();
        if (eon) begin
            flush_held();
            run_bytes.push_back((cfg_decode && cfg_nul) ? CHAR_NUL : CHAR_NL);
        end else begin
            take_byte(b);
        end
        foreach (run_bytes[k]) begin
            expected_bytes.push_back(t_expected_byte'{run_bytes[k], k == run_bytes.size() - 1});
        end
    endfunction

    // Every accepted input transfer is predicted at the edge that accepts it.
    always @(posedge i_clk) begin
        if (i_rst_n && in_bus.valid && in_bus.ready) begin
            predict_transfer(in_bus.data_byte, in_bus.end_of_name);
        end
    end

    // Every accepted output transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
                report_mismatch($sformatf("unexpected output byte 0x%02h", out_bus.out_byte));
            end else begin
                if (out_bus.out_byte !== expected_bytes[0].out_byte) begin
                    report_mismatch($sformatf("out_byte 0x%02h, expected 0x%02h",
                        out_bus.out_byte, expected_bytes[0].out_byte));
                end
                if (out_bus.last_of_run !== expected_bytes[0].last_of_run) begin
                    report_mismatch($sformatf("last_of_run %b, expected %b on byte 0x%02h",
                        out_bus.last_of_run, expected_bytes[0].last_of_run,
                        expected_bytes[0].out_byte));
                end
                void'(expected_bytes.pop_front());
            end
        end
    end

    // The receiver stalls at random according to the current phase.
    always @(posedge i_clk) begin
        out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Drivers.
    // ------------------------------------------------------------------

    // Sends one input transfer. An idle gap, if any, is taken before the
    // item so that valid is never lowered and raised within one step.
    task automatic send_item(input logic [7:0] b, input logic eon);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40) gap++;
        if (gap != 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_bus.valid       <= 1'b1;
        in_bus.data_byte   <= b;
        in_bus.end_of_name <= eon;
        do @(posedge i_clk); while (!in_bus.ready);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_item(s[k], 1'b0);
    endtask

    // The data byte of an end-of-name item is random since the block must
    // ignore it.
    task automatic end_name();
        send_item(8'($urandom_range(255)), 1'b1);
    endtask

    // Stops sending and waits until every expected byte has arrived. The
    // extra cycles cover an item still in flight that yields no byte.
    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // The setup phase, then the access phase until pready is high; the port is left idle before
    // the task returns so that transfers can follow each other directly.
    task automatic apb_transfer(input logic wr, input logic [0:0] idx,
                                input logic [DATA_W-1:0] wdata,
                                output logic [DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Writes a register, updates the predictor and reads the value back.
    task automatic write_register(input logic [0:0] idx, input logic value);
        logic [DATA_W-1:0] readback;
        apb_transfer(1'b1, idx, {{(DATA_W-1){1'b0}}, value}, readback);
        if (idx == REG_DECODE_MODE) cfg_decode = value;
        else cfg_nul = value;
        apb_transfer(1'b0, idx, '0, readback);
        if (readback !== {{(DATA_W-1){1'b0}}, value}) begin
            report_mismatch($sformatf("register %0d reads 0x%08h after writing %b",
                idx, readback, value));
        end
    endtask

    task automatic configure(input logic decode, input logic nul);
        write_register(REG_DECODE_MODE, decode);
        write_register(REG_NUL_TERM, nul);
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Encode mode with the NUL terminator set, which must not matter here:
    // non-printable bytes at both edges of the printable range, NUL itself,
    // a literal backslash-hash-decimal sequence and a name ended while a
    // sequence is half held.
    task automatic test_encode_escapes();
        configure(1'b0, 1'b1);
        send_item(CHAR_NUL, 1'b0);
        send_item(8'h1F, 1'b0);
        send_item(CHAR_DEL, 1'b0);
        send_item(8'hFF, 1'b0);
        send_text("\\#189");
        send_text("\\#4");
        end_name();
        wait_drained();
    endtask

    // Decode mode: the largest octal value wraps to 0xFF, a non-octal digit
    // breaks the sequence, and the name closes with NUL.
    task automatic test_decode_escapes();
        configure(1'b1, 1'b1);
        send_text("\\#777");
        send_text("\\#8");
        end_name();
        wait_drained();
    endtask

    // Two decimal digits are held in encode mode; after the switch to decode
    // they are no longer valid, so completing the sequence flushes them.
    task automatic test_mode_switch_while_held();
        configure(1'b0, 1'b0);
        send_text("\\#89");
        wait_drained();
        write_register(REG_DECODE_MODE, 1'b1);
        send_text("1");
        wait_drained();
    endtask

    // Digits are mostly valid for the current mode so that sequences
    // complete; now and then any decimal digit appears.
    function automatic logic [7:0] random_digit();
        if ($urandom_range(3) == 0) return CHAR_ZERO + 8'($urandom_range(9));
        return CHAR_ZERO + 8'($urandom_range(cfg_decode ? 7 : 9));
    endfunction

    // One piece of a name: complete escape sequences most often, with truncated
    // and broken sequences, printable text and arbitrary bytes mixed in.
    task automatic send_piece();
        int unsigned pick;
        int unsigned depth;
        pick = $urandom_range(99);
        if (pick < 40) begin
            send_item(CHAR_BSL, 1'b0);
            send_item(CHAR_HASH, 1'b0);
            repeat (3) send_item(random_digit(), 1'b0);
        end else if (pick < 55) begin
            depth = $urandom_range(3);
            send_item(CHAR_BSL, 1'b0);
            if (depth >= 1) send_item(CHAR_HASH, 1'b0);
            if (depth >= 2) send_item(random_digit(), 1'b0);
            if (depth >= 3) send_item(random_digit(), 1'b0);
        end else if (pick < 65) begin
            send_item(CHAR_BSL, 1'b0);
            send_item(8'($urandom_range(255)), 1'b0);
        end else if (pick < 85) begin
            send_item(8'($urandom_range(8'h7E, 8'h20)), 1'b0);
        end else begin
            send_item(8'($urandom_range(255)), 1'b0);
        end
    endtask

    task automatic test_random_names(input int unsigned idle_pct, input int unsigned stall_pct,
                                     input logic decode, input logic nul,
                                     input int unsigned budget);
        int unsigned start;
        configure(decode, nul);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = items_sent;
        while (items_sent - start < budget) begin
            send_piece();
            if ($urandom_range(3) == 0) end_name();
        end
        end_name();
        wait_drained();
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_bus.valid       <= 1'b0;
        in_bus.data_byte   <= '0;
        in_bus.end_of_name <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        error_count    = 0;
        items_sent     = 0;
        bytes_checked  = 0;
        cfg_decode     = 1'b0;
        cfg_nul        = 1'b0;
        held_cnt       = PC_IDLE;
        held_dig0      = '0;
        held_dig1      = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_encode_escapes();
        test_decode_escapes();
        test_mode_switch_while_held();

        // Handshake patterns: none, a mostly idle sender, a mostly stalled
        // receiver and light idling on both sides, each under its own setting.
        test_random_names(0, 0, 1'b0, 1'b0, 50);
        test_random_names(71, 0, 1'b1, 1'b1, 50);
        test_random_names(0, 71, 1'b1, 1'b0, 50);
        test_random_names(8, 8, 1'b0, 1'b1, 50);

        repeat (20) @(posedge i_clk);
        if (expected_bytes.size() != 0) begin
            report_mismatch($sformatf("%0d expected bytes never arrived",
                expected_bytes.size()));
        end

        $display("Sent %0d input transfers and checked %0d output transfers,", items_sent,
            bytes_checked);
        $display("in encode and decode modes with both terminators and four handshake patterns.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
